// ===== rtl/byte_budget_lru_cache_core_assert.svh =====
// assertion macros for the byte budget lru cache checker
`ifndef BYTE_BUDGET_LRU_CACHE_CORE_ASSERT_SVH
`define BYTE_BUDGET_LRU_CACHE_CORE_ASSERT_SVH

// same-cycle implication, idle during reset
`define BBL_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbl check failed");

// next-cycle implication, idle during reset
`define BBL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbl check failed");

// next-cycle implication that also watches reset
`define BBL_ASSERT_RST(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bbl check failed");

`endif

// ===== rtl/bbl_pkg.sv =====
// shared types and constants of the byte budget lru cache
`timescale 1ns / 1ps
package bbl_pkg;

  localparam logic [1:0] OP_PUT      = 2'd0;
  localparam logic [1:0] OP_GET      = 2'd1;
  localparam logic [1:0] OP_CONTAINS = 2'd2;
  localparam logic [1:0] OP_CLEAR    = 2'd3;

  localparam logic        ADDR_MAX_BYTES  = 1'b0;
  localparam logic [31:0] MAX_BYTES_RESET = 32'd4194304;

  typedef struct packed {
    logic        is_removal;
    logic        removal_was_replace;
    logic        hit;
    logic [63:0] key;
    logic [31:0] handle;
    logic [23:0] size;
    logic [31:0] total;
    logic [4:0]  count;
    logic        last;
  } out_word_t;

endpackage

// ===== rtl/byte_budget_lru_cache_core.sv =====
// top level of the byte budget lru cache: register port and output fields
// usage:
//   requests enter on in_valid/in_ready with opcode, key, size_bytes and handle.
//   in_ready is high only while the block is idle; one request is worked at a time.
//   every request yields one final word (last high); a put first yields one
//   removal word (is_removal high) per entry it drops, oldest eviction first.
//   words leave on out_valid/out_ready from an output register; a stalled
//   receiver holds the sequencer in its emit step, nothing is dropped.
//   the table lives in a single ram walked one entry at a time, a read then a
//   check per entry. get/contains scan the keys, and a get hit then walks the
//   ranks; a put scans the keys, then per eviction runs a lru scan and a rank
//   update walk, then an insert walk that also finds the free slot; a clear
//   empties the table without a walk.
//   the byte budget max_bytes is written over the apb port at address 0 and
//   reads back there; write it only while the block is idle.
//   reset empties the table, zeroes the byte total and sets max_bytes to
//   4194304; no clearing pass is needed.
`timescale 1ns / 1ps
module byte_budget_lru_cache_core import bbl_pkg::*; #(
  parameter int ENTRIES   = 16,
  parameter int KEY_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [63:0] key,
  input  logic [23:0] size_bytes,
  input  logic [31:0] handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_removal,
  output logic        removal_was_replace,
  output logic        hit,
  output logic [63:0] out_key,
  output logic [31:0] out_handle,
  output logic [23:0] out_size,
  output logic [31:0] total_bytes,
  output logic [4:0]  entry_count,
  output logic        last
);

  logic [31:0] max_bytes;
  out_word_t   word;

  assign pready = 1'b1;

  // register index is the word address
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MAX_BYTES_RESET;
    end else if (psel && penable && pwrite && paddr[2] == ADDR_MAX_BYTES) begin
      max_bytes <= pwdata;
    end
  end

  assign prdata = (paddr[2] == ADDR_MAX_BYTES) ? max_bytes : 32'd0;

  bbl_seq #(
    .ENTRIES  (ENTRIES),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .max_bytes(max_bytes),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_opcode(opcode),
    .in_key   (key),
    .in_size  (size_bytes),
    .in_handle(handle),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (word)
  );

  assign is_removal          = word.is_removal;
  assign removal_was_replace = word.removal_was_replace;
  assign hit                 = word.hit;
  assign out_key             = word.key;
  assign out_handle          = word.handle;
  assign out_size            = word.size;
  assign total_bytes         = word.total;
  assign entry_count         = word.count;
  assign last                = word.last;

endmodule

// ===== rtl/bbl_ram.sv =====
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
module bbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bbl_alu.sv =====
// shared byte total adder, subtractor and budget compare
`timescale 1ns / 1ps
module bbl_alu (
  input  logic [31:0] a,
  input  logic [23:0] b,
  input  logic        sub,
  input  logic [31:0] limit,
  output logic [31:0] res,
  output logic        over
);

  logic [32:0] sum;

  always_comb begin
    if (sub) begin
      sum = {1'b0, a} - {9'd0, b};
    end else begin
      sum = {1'b0, a} + {9'd0, b};
    end
    res  = sum[31:0];
    over = sum > {1'b0, limit};
  end

endmodule

// ===== rtl/bbl_seq.sv =====
// sequencer that walks the entry table for lookups, evictions and rank updates
`timescale 1ns / 1ps
module bbl_seq import bbl_pkg::*; #(
  parameter int ENTRIES   = 16,
  parameter int KEY_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] max_bytes,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [63:0] in_key,
  input  logic [23:0] in_size,
  input  logic [31:0] in_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word
);

  localparam int RW   = $clog2(ENTRIES);
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int RECW = KEY_WIDTH + 32 + 24 + RW;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FIND_RD = 4'd1;
  localparam logic [3:0] S_FIND_EV = 4'd2;
  localparam logic [3:0] S_DROP    = 4'd3;
  localparam logic [3:0] S_ADJ_RD  = 4'd4;
  localparam logic [3:0] S_ADJ_EV  = 4'd5;
  localparam logic [3:0] S_BUDCHK  = 4'd6;
  localparam logic [3:0] S_FULLCHK = 4'd7;
  localparam logic [3:0] S_INSERT  = 4'd8;
  localparam logic [3:0] S_FINAL   = 4'd9;
  localparam logic [3:0] S_CLEAR   = 4'd10;

  localparam logic [2:0] PH_REPL   = 3'd0;
  localparam logic [2:0] PH_BUDGET = 3'd1;
  localparam logic [2:0] PH_FULL   = 3'd2;
  localparam logic [2:0] PH_GET    = 3'd3;
  localparam logic [2:0] PH_CONT   = 3'd4;

  localparam logic [1:0] AM_DEC   = 2'd0;
  localparam logic [1:0] AM_TOUCH = 2'd1;
  localparam logic [1:0] AM_INC   = 2'd2;

  localparam logic [RW-1:0] IDX_LAST = RW'(ENTRIES - 1);

  logic [3:0]           state;
  logic [2:0]           phase;
  logic                 find_lru;
  logic [1:0]           mode;
  logic [RW-1:0]        idx;
  logic [RW-1:0]        slot;
  logic                 slot_ok;
  logic [ENTRIES-1:0]   valid;
  logic [31:0]          total;
  logic [CW-1:0]        count;
  logic [KEY_WIDTH-1:0] req_key;
  logic [23:0]          req_size;
  logic [31:0]          req_handle;
  logic [KEY_WIDTH-1:0] cap_key;
  logic [31:0]          cap_handle;
  logic [23:0]          cap_size;
  logic [RW-1:0]        cap_rank;
  logic                 rem_replace;
  logic                 res_hit;
  logic [31:0]          res_handle;
  logic [23:0]          res_size;

  logic                 we;
  logic [RW-1:0]        waddr;
  logic [RECW-1:0]      wdata;
  logic [RECW-1:0]      rdata;
  logic [KEY_WIDTH-1:0] r_key;
  logic [31:0]          r_handle;
  logic [23:0]          r_size;
  logic [RW-1:0]        r_rank;
  logic                 match;
  logic                 slot_free;
  logic                 emit;
  logic [31:0]          alu_res;
  logic                 alu_over;
  logic                 alu_sub;
  logic [23:0]          alu_b;

  bbl_ram #(
    .WIDTH(RECW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx),
    .rdata(rdata)
  );

  assign alu_sub = (state == S_DROP);
  assign alu_b   = (state == S_DROP) ? cap_size : req_size;

  bbl_alu u_alu (
    .a    (total),
    .b    (alu_b),
    .sub  (alu_sub),
    .limit(max_bytes),
    .res  (alu_res),
    .over (alu_over)
  );

  assign r_key    = rdata[RECW-1 -: KEY_WIDTH];
  assign r_handle = rdata[RW + 24 +: 32];
  assign r_size   = rdata[RW +: 24];
  assign r_rank   = rdata[RW-1:0];

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  // a new word is loaded into the output register this cycle
  assign emit      = slot_free && (state == S_DROP || state == S_FINAL);

  // lru entry holds rank count-1
  always_comb begin
    if (find_lru) begin
      match = valid[idx] && ((CW'(r_rank) + CW'(1)) == count);
    end else begin
      match = valid[idx] && (r_key == req_key);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = rdata;
    if (state == S_ADJ_EV) begin
      case (mode)
        AM_DEC: begin
          if (valid[idx] && r_rank > cap_rank) begin
            we          = 1'b1;
            wdata[RW-1:0] = r_rank - RW'(1);
          end
        end
        AM_TOUCH: begin
          if (idx == slot) begin
            we          = 1'b1;
            wdata[RW-1:0] = '0;
          end else if (valid[idx] && r_rank < cap_rank) begin
            we          = 1'b1;
            wdata[RW-1:0] = r_rank + RW'(1);
          end
        end
        AM_INC: begin
          if (valid[idx]) begin
            we          = 1'b1;
            wdata[RW-1:0] = r_rank + RW'(1);
          end
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end else if (state == S_INSERT) begin
      we    = slot_ok;
      waddr = slot;
      wdata = {req_key, req_handle, req_size, {RW{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      total     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
      slot_ok   <= 1'b0;
      phase     <= PH_REPL;
      mode      <= AM_DEC;
      find_lru  <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_key     <= in_key[KEY_WIDTH-1:0];
            req_size    <= in_size;
            req_handle  <= in_handle;
            res_hit     <= 1'b0;
            res_handle  <= '0;
            res_size    <= '0;
            rem_replace <= 1'b0;
            idx         <= '0;
            find_lru    <= 1'b0;
            case (in_opcode)
              OP_PUT: begin
                phase <= PH_REPL;
                state <= S_FIND_RD;
              end
              OP_GET: begin
                phase <= PH_GET;
                state <= S_FIND_RD;
              end
              OP_CONTAINS: begin
                phase <= PH_CONT;
                state <= S_FIND_RD;
              end
              default: begin
                state <= S_CLEAR;
              end
            endcase
          end
        end
        S_FIND_RD: begin
          state <= S_FIND_EV;
        end
        S_FIND_EV: begin
          if (match) begin
            cap_key    <= r_key;
            cap_handle <= r_handle;
            cap_size   <= r_size;
            cap_rank   <= r_rank;
            slot       <= idx;
            case (phase)
              PH_REPL: begin
                rem_replace <= 1'b1;
                state       <= S_DROP;
              end
              PH_GET: begin
                res_hit    <= 1'b1;
                res_handle <= r_handle;
                res_size   <= r_size;
                mode       <= AM_TOUCH;
                idx        <= '0;
                state      <= S_ADJ_RD;
              end
              PH_CONT: begin
                res_hit  <= 1'b1;
                res_size <= r_size;
                state    <= S_FINAL;
              end
              default: begin
                rem_replace <= 1'b0;
                state       <= S_DROP;
              end
            endcase
          end else if (idx == IDX_LAST) begin
            case (phase)
              PH_REPL: begin
                state <= S_BUDCHK;
              end
              PH_BUDGET: begin
                state <= S_FULLCHK;
              end
              PH_FULL: begin
                mode    <= AM_INC;
                idx     <= '0;
                slot_ok <= 1'b0;
                state   <= S_ADJ_RD;
              end
              default: begin
                state <= S_FINAL;
              end
            endcase
          end else begin
            idx   <= idx + RW'(1);
            state <= S_FIND_RD;
          end
        end
        S_DROP: begin
          if (slot_free) begin
            valid[slot]                  <= 1'b0;
            total                        <= alu_res;
            count                        <= count - CW'(1);
            out_valid                    <= 1'b1;
            out_word.is_removal          <= 1'b1;
            out_word.removal_was_replace <= rem_replace;
            out_word.hit                 <= 1'b0;
            out_word.key                 <= 64'(cap_key);
            out_word.handle              <= cap_handle;
            out_word.size                <= cap_size;
            out_word.total               <= alu_res;
            out_word.count               <= 5'(count - CW'(1));
            out_word.last                <= 1'b0;
            mode                         <= AM_DEC;
            idx                          <= '0;
            state                        <= S_ADJ_RD;
          end
        end
        S_ADJ_RD: begin
          state <= S_ADJ_EV;
        end
        S_ADJ_EV: begin
          if (mode == AM_INC && !valid[idx] && !slot_ok) begin
            slot    <= idx;
            slot_ok <= 1'b1;
          end
          if (idx == IDX_LAST) begin
            case (mode)
              AM_DEC: begin
                if (phase == PH_FULL) begin
                  mode    <= AM_INC;
                  idx     <= '0;
                  slot_ok <= 1'b0;
                  state   <= S_ADJ_RD;
                end else begin
                  state <= S_BUDCHK;
                end
              end
              AM_TOUCH: begin
                state <= S_FINAL;
              end
              default: begin
                state <= S_INSERT;
              end
            endcase
          end else begin
            idx   <= idx + RW'(1);
            state <= S_ADJ_RD;
          end
        end
        S_BUDCHK: begin
          if (count != '0 && alu_over) begin
            phase    <= PH_BUDGET;
            find_lru <= 1'b1;
            idx      <= '0;
            state    <= S_FIND_RD;
          end else begin
            state <= S_FULLCHK;
          end
        end
        S_FULLCHK: begin
          if (count >= CW'(ENTRIES)) begin
            phase    <= PH_FULL;
            find_lru <= 1'b1;
            idx      <= '0;
            state    <= S_FIND_RD;
          end else begin
            mode    <= AM_INC;
            idx     <= '0;
            slot_ok <= 1'b0;
            state   <= S_ADJ_RD;
          end
        end
        S_INSERT: begin
          if (slot_ok) begin
            valid[slot] <= 1'b1;
            total       <= alu_res;
            count       <= count + CW'(1);
          end
          state <= S_FINAL;
        end
        S_FINAL: begin
          if (slot_free) begin
            out_valid                    <= 1'b1;
            out_word.is_removal          <= 1'b0;
            out_word.removal_was_replace <= 1'b0;
            out_word.hit                 <= res_hit;
            out_word.key                 <= 64'(req_key);
            out_word.handle              <= res_handle;
            out_word.size                <= res_size;
            out_word.total               <= total;
            out_word.count               <= 5'(count);
            out_word.last                <= 1'b1;
            state                        <= S_IDLE;
          end
        end
        S_CLEAR: begin
          valid <= '0;
          total <= '0;
          count <= '0;
          state <= S_FINAL;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/bbl_checker.sv =====
// port level checks of the byte budget lru cache, bound to the top level
`timescale 1ns / 1ps
`include "byte_budget_lru_cache_core_assert.svh"
module bbl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        is_removal,
  input logic        hit,
  input logic        last,
  input logic [63:0] out_key
);

  `BBL_ASSERT_RST(a_reset_idle, rst, !out_valid && in_ready)
  `BBL_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  `BBL_ASSERT_NOW(a_nonfinal_is_removal, out_valid && !last, is_removal)
  `BBL_ASSERT_NOW(a_removal_no_hit, out_valid && is_removal, !hit && !last)
  `BBL_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_key))

endmodule

bind byte_budget_lru_cache_core bbl_checker u_bbl_checker (.*);
